### rtl/rlkd_pkg.sv
package rlkd_pkg;

  // Sample and calibration geometry.
  localparam int SAMPLE_BITS = 10;
  localparam int CAL_SAMPLES = 8;
  localparam int MAX_KEYS    = 4;
  localparam int CAL_IDX_W   = $clog2(CAL_SAMPLES);
  localparam int MEM_ADDR_W  = CAL_IDX_W + 1;

  // Derived datapath widths.
  localparam int SPAN_W   = SAMPLE_BITS + 1;
  localparam int GUARD_W  = SAMPLE_BITS + 2;
  localparam int BOUND_W  = SAMPLE_BITS + 3;
  localparam int SUM_W    = SAMPLE_BITS + 2;
  localparam int RATIO_W  = 16;
  localparam int RSUM_W   = RATIO_W + 1;
  localparam int MUL_A_W  = RSUM_W + 1;
  localparam int MUL_B_W  = SPAN_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int RATIO_SHIFT = 16;

  // Five percent is taken as a multiply by round(2^16 / 20) and a shift by 16.
  localparam int GUARD_RECIP = 3277;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_KEY_COUNT     = 2'd0;
  localparam logic [1:0] REG_CONFIRM_COUNT = 2'd1;
  localparam logic [1:0] REG_RATIO_TABLE   = 2'd2;

  // Result codes.
  localparam logic [2:0] CODE_NONE = 3'd0;
  localparam logic [2:0] CODE_LOW  = 3'd1;
  localparam logic [2:0] CODE_HIGH = 3'd2;
  localparam logic [2:0] CODE_KEY0 = 3'd3;

  localparam logic [3:0] CLASS_NONE = 4'd15;
  localparam logic [7:0] REPEAT_MAX = 8'hff;

  typedef struct packed {
    logic                   we;
    logic [MEM_ADDR_W-1:0]  waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [MEM_ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

endpackage

### rtl/resistor_ladder_key_decoder_top.sv
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------
// sample    | sample_valid, sample_stall | kind, sample, second_sample
// code      | code_valid, code_stall     | key_code, cal_done
// cfg       | cfg_we (no wait)           | cfg_index, cfg_data
//
// A key beat that lands outside a guard goes straight to debounce; otherwise it
// scans the ladder windows in turn, each window costing one pass of the shared
// multiplier. A calibration beat writes its pair and is done, except the one that
// completes a set: it ranks both sets of eight samples through one comparator
// and one memory read port and then derives the guards. Synchronous reset
// restores the register defaults and the calibration state; the sample memory
// is not cleared. The sample channel is stalled while an item is in work; a
// stalled code channel holds the finished beat, and the next sample beat is
// still taken, but its result then waits and stalls the sample channel too.
module resistor_ladder_key_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [63:0]                       cfg_data,
  // Sample channel.
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic                              kind,
  input  logic [rlkd_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic [rlkd_pkg::SAMPLE_BITS-1:0]  second_sample,
  // Code channel.
  output logic                              code_valid,
  input  logic                              code_stall,
  output logic [2:0]                        key_code,
  output logic                              cal_done
);
  import rlkd_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_WR_LOW     = 4'd1;
  localparam logic [3:0] ST_SORT_PIVOT = 4'd2;
  localparam logic [3:0] ST_SORT_PWAIT = 4'd3;
  localparam logic [3:0] ST_SORT_CMP   = 4'd4;
  localparam logic [3:0] ST_SORT_ACC   = 4'd5;
  localparam logic [3:0] ST_SORT_END   = 4'd6;
  localparam logic [3:0] ST_GUARD_MUL  = 4'd7;
  localparam logic [3:0] ST_GUARD_ADD  = 4'd8;
  localparam logic [3:0] ST_KEY_CLASS  = 4'd9;
  localparam logic [3:0] ST_KEY_MUL    = 4'd10;
  localparam logic [3:0] ST_KEY_WIN    = 4'd11;
  localparam logic [3:0] ST_KEY_DEB    = 4'd12;
  localparam logic [3:0] ST_RESULT     = 4'd13;

  // Configuration registers.
  logic [2:0]  key_count;
  logic [7:0]  confirm_count;
  logic [63:0] ratio_table;

  // Control and calibration state.
  logic [3:0]                  state;
  logic [CAL_IDX_W-1:0]        cal_index;
  logic [SAMPLE_BITS-1:0]      ref_high_level;
  logic [SAMPLE_BITS-1:0]      ref_low_level;
  logic signed [SPAN_W-1:0]    span;
  logic signed [GUARD_W-1:0]   low_guard;
  logic signed [GUARD_W-1:0]   high_guard;
  logic [3:0]                  last_class;
  logic [7:0]                  repeat_count;

  // Working registers of the sequencer.
  logic [SAMPLE_BITS-1:0]      val;
  logic [SAMPLE_BITS-1:0]      low_hold;
  logic                        set_sel;
  logic [CAL_IDX_W-1:0]        pos_j;
  logic [CAL_IDX_W-1:0]        pos_k;
  logic [CAL_IDX_W-1:0]        rank;
  logic [SAMPLE_BITS-1:0]      pivot;
  logic [SUM_W-1:0]            sum;
  logic [1:0]                  win;
  logic signed [BOUND_W-1:0]   prev_bound;
  logic [2:0]                  cls;
  logic [2:0]                  res_code;
  logic                        res_cal;

  mem_req_t                    mem_req;
  logic [SAMPLE_BITS-1:0]      rd_data;
  mul_req_t                    mul_req;
  logic signed [PROD_W-1:0]    prod;

  rlkd_sample_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  rlkd_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  logic sample_accept;
  assign sample_stall  = (state != ST_IDLE);
  assign sample_accept = sample_valid && !sample_stall;

  // The output slot can take a new beat when it is empty or draining now.
  logic slot_free;
  assign slot_free = !code_valid || !code_stall;

  // Number of ladder keys actually scanned.
  logic [2:0] keys_n;
  assign keys_n = (key_count > 3'(MAX_KEYS)) ? 3'(MAX_KEYS) : key_count;

  // Memory port: writes store a calibration pair, the rail-high sample on
  // acceptance and the rail-low one in ST_WR_LOW; reads walk the set being ranked.
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = {1'b0, cal_index};
    mem_req.wdata = sample;
    mem_req.raddr = {set_sel, pos_j};
    case (state)
      ST_IDLE: begin
        mem_req.we = sample_accept && kind;
      end
      ST_WR_LOW: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {1'b1, cal_index};
        mem_req.wdata = low_hold;
      end
      ST_SORT_PWAIT: begin
        mem_req.raddr = {set_sel, {CAL_IDX_W{1'b0}}};
      end
      ST_SORT_CMP: begin
        mem_req.raddr = {set_sel, pos_k + 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Rank comparator: an element ranks below the pivot when it is smaller, or
  // equal and stored earlier, so every element gets a distinct rank.
  logic below_pivot;
  assign below_pivot = (rd_data < pivot) || ((rd_data == pivot) && (pos_k < pos_j));

  logic [SUM_W-1:0] sum_round;
  assign sum_round = sum + SUM_W'(2);

  // Shared multiplier operands: the guard offset during calibration, a ladder
  // window bound while scanning keys.
  logic [SPAN_W-1:0]  span_abs;
  logic [RSUM_W-1:0]  ratio_sum;
  logic [1:0]         win_up;
  assign span_abs  = span[SPAN_W-1] ? SPAN_W'(-span) : span;
  assign win_up    = win + 2'd1;
  assign ratio_sum = RSUM_W'(ratio_table[RATIO_W*win +: RATIO_W])
                   + RSUM_W'(ratio_table[RATIO_W*win_up +: RATIO_W]);

  always_comb begin
    if (state == ST_GUARD_MUL) begin
      mul_req.a = MUL_A_W'(GUARD_RECIP);
      mul_req.b = $signed({1'b0, span_abs});
    end else begin
      mul_req.a = $signed({1'b0, ratio_sum});
      mul_req.b = MUL_B_W'(span);
    end
  end

  // Guard offset: the magnitude of span / 20, given the sign of span.
  logic [GUARD_W-1:0]        guard_q;
  logic signed [GUARD_W-1:0] guard_d;
  assign guard_q = prod[RATIO_SHIFT +: GUARD_W];
  assign guard_d = span[SPAN_W-1] ? -$signed(guard_q) : $signed(guard_q);

  logic signed [SPAN_W-1:0] span_next;
  logic [SAMPLE_BITS-1:0]   ref_next;
  assign ref_next  = sum_round[SUM_W-1:2];
  assign span_next = $signed({1'b0, ref_high_level}) - $signed({1'b0, ref_next});

  // Window test against the bound just produced (floor of the product / 2^16).
  logic signed [BOUND_W-1:0] cur_bound;
  logic signed [BOUND_W-1:0] val_b;
  logic signed [BOUND_W-1:0] low_guard_b;
  logic signed [BOUND_W-1:0] high_guard_b;
  logic                      win_last;
  logic                      win_hit;
  assign cur_bound    = prod[RATIO_SHIFT +: BOUND_W];
  assign val_b        = $signed({3'b000, val});
  assign low_guard_b  = BOUND_W'(low_guard);
  assign high_guard_b = BOUND_W'(high_guard);
  assign win_last     = ({1'b0, win} == keys_n - 3'd1);

  always_comb begin
    if (win == 2'd0) begin
      win_hit = (val_b > low_guard_b) && (val_b < cur_bound);
    end else if (win_last) begin
      win_hit = (val_b < high_guard_b) && (val_b > prev_bound);
    end else begin
      win_hit = (val_b > prev_bound) && (val_b < cur_bound);
    end
  end

  logic signed [GUARD_W-1:0] val_g;
  assign val_g = $signed({2'b00, val});

  // Debounce: count equal classifications in a row, saturating.
  logic [7:0] repeat_next;
  always_comb begin
    if (last_class == {1'b0, cls}) begin
      repeat_next = (repeat_count < REPEAT_MAX) ? repeat_count + 8'd1 : repeat_count;
    end else begin
      repeat_next = 8'd1;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count     <= 3'd4;
      confirm_count <= 8'd3;
      ratio_table   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_COUNT:     key_count     <= cfg_data[2:0];
        REG_CONFIRM_COUNT: confirm_count <= cfg_data[7:0];
        REG_RATIO_TABLE:   ratio_table   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cal_index      <= '0;
      ref_high_level <= '0;
      ref_low_level  <= '0;
      span           <= '0;
      low_guard      <= '0;
      high_guard     <= '0;
      last_class     <= CLASS_NONE;
      repeat_count   <= 8'd1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample_accept) begin
            val      <= sample;
            low_hold <= second_sample;
            state    <= kind ? ST_WR_LOW : ST_KEY_CLASS;
          end
        end
        ST_WR_LOW: begin
          res_code <= CODE_NONE;
          if (cal_index == CAL_IDX_W'(CAL_SAMPLES - 1)) begin
            set_sel <= 1'b0;
            pos_j   <= '0;
            sum     <= '0;
            state   <= ST_SORT_PIVOT;
          end else begin
            cal_index <= cal_index + 1'b1;
            res_cal   <= 1'b0;
            state     <= ST_RESULT;
          end
        end
        ST_SORT_PIVOT: begin
          state <= ST_SORT_PWAIT;
        end
        ST_SORT_PWAIT: begin
          pivot <= rd_data;
          pos_k <= '0;
          rank  <= '0;
          state <= ST_SORT_CMP;
        end
        ST_SORT_CMP: begin
          rank  <= rank + CAL_IDX_W'(below_pivot);
          pos_k <= pos_k + 1'b1;
          if (pos_k == CAL_IDX_W'(CAL_SAMPLES - 1)) begin
            state <= ST_SORT_ACC;
          end
        end
        ST_SORT_ACC: begin
          // The middle four ranks of eight contribute to the reference.
          if (rank >= CAL_IDX_W'(2) && rank <= CAL_IDX_W'(5)) begin
            sum <= sum + SUM_W'(pivot);
          end
          pos_j <= pos_j + 1'b1;
          state <= (pos_j == CAL_IDX_W'(CAL_SAMPLES - 1)) ? ST_SORT_END : ST_SORT_PIVOT;
        end
        ST_SORT_END: begin
          sum   <= '0;
          pos_j <= '0;
          if (!set_sel) begin
            ref_high_level <= ref_next;
            set_sel        <= 1'b1;
            state          <= ST_SORT_PIVOT;
          end else begin
            ref_low_level <= ref_next;
            span          <= span_next;
            state         <= ST_GUARD_MUL;
          end
        end
        ST_GUARD_MUL: begin
          state <= ST_GUARD_ADD;
        end
        ST_GUARD_ADD: begin
          low_guard  <= $signed({2'b00, ref_low_level}) + guard_d;
          high_guard <= $signed({2'b00, ref_high_level}) - guard_d;
          cal_index  <= '0;
          res_cal    <= 1'b1;
          state      <= ST_RESULT;
        end
        ST_KEY_CLASS: begin
          win        <= 2'd0;
          prev_bound <= '0;
          if (val_g < low_guard) begin
            cls   <= CODE_LOW;
            state <= ST_KEY_DEB;
          end else if (val_g > high_guard) begin
            cls   <= CODE_HIGH;
            state <= ST_KEY_DEB;
          end else if (keys_n == 3'd0) begin
            cls   <= CODE_KEY0;
            state <= ST_KEY_DEB;
          end else begin
            state <= ST_KEY_MUL;
          end
        end
        ST_KEY_MUL: begin
          state <= ST_KEY_WIN;
        end
        ST_KEY_WIN: begin
          if (win_hit) begin
            cls   <= CODE_KEY0 + 3'(win);
            state <= ST_KEY_DEB;
          end else if (win_last) begin
            cls   <= CODE_KEY0 + keys_n;
            state <= ST_KEY_DEB;
          end else begin
            prev_bound <= cur_bound;
            win        <= win + 2'd1;
            state      <= ST_KEY_MUL;
          end
        end
        ST_KEY_DEB: begin
          last_class   <= {1'b0, cls};
          repeat_count <= repeat_next;
          res_code     <= (repeat_next >= confirm_count) ? cls : CODE_NONE;
          res_cal      <= 1'b0;
          state        <= ST_RESULT;
        end
        ST_RESULT: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output slot: filled by a finished beat, emptied when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
    end else if (state == ST_RESULT && slot_free) begin
      code_valid <= 1'b1;
    end else if (code_valid && !code_stall) begin
      code_valid <= 1'b0;
    end
  end

  // Output payload registers, loaded as the finished beat enters the slot.
  always_ff @(posedge clk) begin
    if (state == ST_RESULT && slot_free) begin
      key_code <= res_code;
      cal_done <= res_cal;
    end
  end

`ifndef ASSERT_OFF
  // An accepted sample beat always starts work in the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> state != ST_IDLE)
    else $error("accepted beat did not leave idle");

  // A completed calibration never reports a key.
  assert property (@(posedge clk) disable iff (rst)
    code_valid && cal_done |-> key_code == CODE_NONE)
    else $error("calibration beat carries a key code");

  // Ranking only starts once the last slot of the set has been written.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SORT_PIVOT |-> cal_index == CAL_IDX_W'(CAL_SAMPLES - 1))
    else $error("ranking started on an incomplete set");

  // The debounce counter never wraps to zero.
  assert property (@(posedge clk) disable iff (rst)
    repeat_count != 8'd0)
    else $error("debounce counter wrapped");
`endif

endmodule

### rtl/rlkd_sample_mem.sv
module rlkd_sample_mem (
  input  logic                            clk,
  input  rlkd_pkg::mem_req_t              req,
  output logic [rlkd_pkg::SAMPLE_BITS-1:0] rd_data
);
  import rlkd_pkg::*;

  // Rail-high samples sit in the lower half, rail-low samples in the upper half.
  logic [SAMPLE_BITS-1:0] mem [2*CAL_SAMPLES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

### rtl/rlkd_mul.sv
module rlkd_mul (
  input  logic                                  clk,
  input  rlkd_pkg::mul_req_t                    req,
  output logic signed [rlkd_pkg::PROD_W-1:0]    prod
);
  import rlkd_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(req.a * req.b);
  end

endmodule
